// ===== rtl/lmfd_pkg.sv =====
// Package for the lattice drift block: types, constants and rounding helpers.
// No dependencies.
package lmfd_pkg;
    localparam int WORDS = 8;
    localparam logic signed [33:0] FOUR_Q16 = 34'sh0_0004_0000;
    // ceil(2^34 / 6): floor(n / 6) == (n * RECIP6) >> 34 for any n below 2^32
    localparam logic signed [33:0] RECIP6 = 34'sh0_aaaa_aaab;
    localparam logic [1:0] REG_MASS = 2'd0;
    localparam logic [1:0] REG_COUP = 2'd1;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRIFT = 1'b1;

    typedef logic signed [31:0] t_word;
    typedef t_word [WORDS-1:0] t_site;

    // round half up of a Q32.32 product to Q16.16, 50 bits kept
    function automatic logic signed [49:0] rnd16(input logic signed [66:0] p);
        logic signed [66:0] q;
        q = p + 67'sd32768;
        return q[65:16];
    endfunction

    function automatic t_word sat32(input logic signed [49:0] x);
        if (x > 50'sd2147483647) return 32'sh7fffffff;
        if (x < -50'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction
endpackage

// ===== rtl/lattice_matrix_field_drift.sv =====
// Lattice drift evaluator top level: APB registers, site memory, sequencer
// and one shared 34x34 multiplier. Depends on lmfd_pkg.
//
// Usage: drive start with the request fields; a request is taken at the edge
// where start is high and busy is low. A write request (command 0) stores the
// site matrix in S_WRITE and then returns to idle.
// A drift request (command 1) reads the site and its four periodic
// neighbours, one memory read a cycle, then pushes 35 products
// through the single multiplier: 8 for the determinant, 1 for the coupling
// over six, 2 for the quartic factor, 8 for the mass term, 16 for the quartic
// term. o_valid rises when S_OUT registers the saturated sums, and the next
// request can be taken at the edge that ends the result cycle; no new request
// is taken while a drift is in progress. With an extent below 32, a coordinate
// at or past it is wrapped by repeated subtraction of the extent in S_RMOD.
// The result is on o_drift_* for exactly one cycle with o_valid high; the
// receiver cannot stall it and nothing is buffered.
// Reset (synchronous, active low) clears the sequencer and both registers;
// the site memory is undefined until written and has no clear.
// Registers: mass_squared at 0x0, quartic_coupling at 0x4, read back on
// prdata. Write registers only while busy is low.
module lattice_matrix_field_drift
    import lmfd_pkg::*;
#(
    parameter int TIME_EXTENT  = 32,
    parameter int SPACE_EXTENT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_command,
    input  logic [4:0]  i_site_time,
    input  logic [4:0]  i_site_space,
    input  logic signed [31:0] i_top_left_re,
    input  logic signed [31:0] i_top_left_im,
    input  logic signed [31:0] i_top_right_re,
    input  logic signed [31:0] i_top_right_im,
    input  logic signed [31:0] i_bottom_left_re,
    input  logic signed [31:0] i_bottom_left_im,
    input  logic signed [31:0] i_bottom_right_re,
    input  logic signed [31:0] i_bottom_right_im,
    output logic        o_valid,
    output logic signed [31:0] o_drift_top_left_re,
    output logic signed [31:0] o_drift_top_left_im,
    output logic signed [31:0] o_drift_top_right_re,
    output logic signed [31:0] o_drift_top_right_im,
    output logic signed [31:0] o_drift_bottom_left_re,
    output logic signed [31:0] o_drift_bottom_left_im,
    output logic signed [31:0] o_drift_bottom_right_re,
    output logic signed [31:0] o_drift_bottom_right_im
);
    localparam int TW    = $clog2(TIME_EXTENT);
    localparam int SW    = $clog2(SPACE_EXTENT);
    localparam int DEPTH = TIME_EXTENT * SPACE_EXTENT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_RMOD, S_WRITE, S_READ, S_DET, S_C6, S_K, S_MASS, S_Q, S_OUT
    } t_state;

    // ---------------- configuration port
    logic [31:0] r_mass, r_coup;
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= '0;
            r_coup <= '0;
        end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
            case ({1'b0, paddr[2]})
                REG_MASS: r_mass <= pwdata;
                REG_COUP: r_coup <= pwdata;
                default: ;
            endcase
        end
    end
    assign prdata = paddr[2] ? r_coup : r_mass;

    // ---------------- site memory
    t_site r_mem [DEPTH];
    t_site r_rd;
    logic         mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    t_site        mem_wd;
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    // ---------------- sequencer state
    t_state r_state;
    logic   r_cmd;
    logic [4:0] r_t5, r_s5;
    logic [TW-1:0] r_t;
    logic [SW-1:0] r_s;
    t_site  r_in, r_m;
    logic signed [33:0] r_nsum [WORDS];
    logic [3:0] r_cnt;
    logic signed [49:0] r_acc [WORDS];
    logic signed [49:0] r_acc_dr, r_acc_di;
    logic signed [31:0] r_dr, r_di, r_kr, r_ki;
    logic signed [33:0] r_c;
    logic [33:0] r_cmag;        // |coupling + 3| (plus 5 when negative)
    logic        r_cneg;
    logic signed [66:0] r_prod;
    t_state      r_pst;         // state at product issue
    logic [3:0]  r_pidx;        // step count at product issue
    logic        r_valid;
    t_site       r_out;

    function automatic logic [AW-1:0] addr(input logic [TW-1:0] t, input logic [SW-1:0] s);
        logic [AW+TW:0] a;
        a = (AW+TW+1)'(t) * (AW+TW+1)'(SPACE_EXTENT) + (AW+TW+1)'(s);
        return a[AW-1:0];
    endfunction

    // coordinate wrap: one subtraction of the extent per cycle
    logic t_over, s_over;
    assign t_over = ({6'd0, r_t5} >= 11'(TIME_EXTENT));
    assign s_over = ({6'd0, r_s5} >= 11'(SPACE_EXTENT));

    logic [TW-1:0] tp, tm;
    logic [SW-1:0] sp, sm;
    assign tp = (r_t == TW'(TIME_EXTENT-1)) ? '0 : r_t + 1'b1;
    assign tm = (r_t == '0) ? TW'(TIME_EXTENT-1) : r_t - 1'b1;
    assign sp = (r_s == SW'(SPACE_EXTENT-1)) ? '0 : r_s + 1'b1;
    assign sm = (r_s == '0) ? SW'(SPACE_EXTENT-1) : r_s - 1'b1;

    // read order: site, t+1, t-1, s+1, s-1
    always_comb begin
        case (r_cnt[2:0])
            3'd0:    mem_ra = addr(r_t, r_s);
            3'd1:    mem_ra = addr(tp, r_s);
            3'd2:    mem_ra = addr(tm, r_s);
            3'd3:    mem_ra = addr(r_t, sp);
            default: mem_ra = addr(r_t, sm);
        endcase
    end
    assign mem_we = (r_state == S_WRITE);
    assign mem_wa = addr(r_t, r_s);
    assign mem_wd = r_in;

    // ---------------- shared multiplier: operand select by step
    // DET: cnt[2] picks tl*br or tr*bl, cnt[1:0] the term:
    //   0 ar*br re+, 1 ai*bi re-, 2 ar*bi im+, 3 ai*br im+
    // Q: cnt[3:2] element pair, cnt[1:0] the term:
    //   0 kr*mr re-, 1 ki*mi re+, 2 kr*mi im-, 3 ki*mr im-
    logic [2:0] det_a, det_b, q_b, q_el;
    logic       det_neg;
    assign det_a   = {1'b0, r_cnt[2], r_cnt[0]};
    assign det_b   = {1'b1, ~r_cnt[2], r_cnt[1] ^ r_cnt[0]};
    assign q_b     = {r_cnt[3:2], r_cnt[1] ^ r_cnt[0]};
    assign q_el    = {r_pidx[3:2], r_pidx[1]};
    assign det_neg = r_pidx[2] ^ (r_pidx[1:0] == 2'd1);

    logic signed [33:0] ma, mb;
    logic signed [33:0] scale;
    assign scale = FOUR_Q16 + 34'(signed'(r_mass));
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            S_DET: begin
                ma = 34'(r_m[det_a]);
                mb = 34'(r_m[det_b]);
            end
            S_C6: begin
                ma = signed'(r_cmag);
                mb = RECIP6;
            end
            S_K: begin
                ma = r_c;
                mb = r_cnt[0] ? 34'(r_di) : 34'(r_dr);
            end
            S_MASS: begin
                ma = scale;
                mb = 34'(r_m[r_cnt[2:0]]);
            end
            S_Q: begin
                ma = r_cnt[0] ? 34'(r_ki) : 34'(r_kr);
                mb = 34'(r_m[q_b]);
            end
            default: ;
        endcase
    end

    logic signed [49:0] pr;
    assign pr = rnd16(r_prod);

    // coupling over six: floor((x) / 6), negative side as -((-x + 5) / 6)
    logic signed [34:0] c_bias, c_negmag;
    logic signed [33:0] c_quot;
    assign c_bias   = 35'(signed'(r_coup)) + 35'sd3;
    assign c_negmag = 35'sd5 - c_bias;
    assign c_quot   = signed'({2'b00, r_prod[65:34]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_pst   <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_valid <= 1'b0;
            r_prod  <= ma * mb;
            r_pidx  <= r_cnt;
            r_pst   <= r_state;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd <= i_command;
                        r_t5  <= i_site_time;
                        r_s5  <= i_site_space;
                        r_in  <= {i_bottom_right_im, i_bottom_right_re,
                                  i_bottom_left_im, i_bottom_left_re,
                                  i_top_right_im, i_top_right_re,
                                  i_top_left_im, i_top_left_re};
                        r_state <= S_RMOD;
                    end
                end
                S_RMOD: begin
                    if (t_over) r_t5 <= r_t5 - 5'(TIME_EXTENT);
                    if (s_over) r_s5 <= r_s5 - 5'(SPACE_EXTENT);
                    if (!t_over && !s_over) begin
                        r_t <= TW'(r_t5);
                        r_s <= SW'(r_s5);
                        r_cnt <= '0;
                        r_state <= (r_cmd == CMD_DRIFT) ? S_READ : S_WRITE;
                    end
                end
                S_WRITE: r_state <= S_IDLE;
                S_READ: begin
                    // read data for address cnt-1 arrives now
                    if (r_cnt == 4'd1) r_m <= r_rd;
                    for (int e = 0; e < WORDS; e++) begin
                        if (r_cnt == 4'd2) r_nsum[e] <= 34'(r_rd[e]);
                        else if (r_cnt > 4'd2) r_nsum[e] <= r_nsum[e] + 34'(r_rd[e]);
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd5) begin
                        r_cnt <= '0;
                        r_state <= S_DET;
                    end
                end
                S_DET: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd7) begin
                        r_cnt  <= '0;
                        r_cneg <= c_bias[34];
                        r_cmag <= c_bias[34] ? c_negmag[33:0] : c_bias[33:0];
                        r_state <= S_C6;
                    end
                end
                S_C6: begin
                    // step 0 issues the reciprocal product, step 1 takes it
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd1) begin
                        r_c  <= r_cneg ? -c_quot : c_quot;
                        r_dr <= sat32(r_acc_dr);
                        r_di <= sat32(r_acc_di);
                        r_cnt <= '0;
                        r_state <= S_K;
                    end
                end
                S_K: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd1) begin
                        r_cnt <= '0;
                        r_state <= S_MASS;
                    end
                end
                S_MASS: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd7) begin
                        r_cnt <= '0;
                        r_state <= S_Q;
                    end
                end
                S_Q: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) begin
                        r_cnt <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // last quartic product lands in step 0
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd1) begin
                        for (int e = 0; e < WORDS; e++)
                            r_out[e] <= sat32(r_acc[e]);
                        r_valid <= 1'b1;
                        r_cnt <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // products accumulate in the cycle after issue, tagged by issuing state
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_acc_dr <= '0;
            r_acc_di <= '0;
        end else if (r_pst == S_DET) begin
            if (r_pidx[1]) r_acc_di <= det_neg ? r_acc_di - pr : r_acc_di + pr;
            else           r_acc_dr <= det_neg ? r_acc_dr - pr : r_acc_dr + pr;
        end

        if (r_pst == S_K) begin
            if (r_pidx[0]) r_ki <= sat32(pr);
            else           r_kr <= sat32(pr);
        end

        // output sums start from the neighbour sum, then mass and quartic
        // terms come off
        if (r_state == S_K) begin
            for (int e = 0; e < WORDS; e++)
                r_acc[e] <= 50'(r_nsum[e]);
        end else if (r_pst == S_MASS) begin
            r_acc[r_pidx[2:0]] <= r_acc[r_pidx[2:0]] - pr;
        end else if (r_pst == S_Q) begin
            r_acc[q_el] <= (r_pidx[1:0] == 2'd1) ? r_acc[q_el] + pr : r_acc[q_el] - pr;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_drift_top_left_re     = r_out[0];
    assign o_drift_top_left_im     = r_out[1];
    assign o_drift_top_right_re    = r_out[2];
    assign o_drift_top_right_im    = r_out[3];
    assign o_drift_bottom_left_re  = r_out[4];
    assign o_drift_bottom_left_im  = r_out[5];
    assign o_drift_bottom_right_re = r_out[6];
    assign o_drift_bottom_right_im = r_out[7];

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than a cycle");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request accepted but not busy");
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> !o_valid) else $error("write produced a result");
endmodule
